/* design/sps_pkg.sv */
package sps_pkg;

  localparam int MAX_EXTRA_POINTS_DEF = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TOLERANCE = 2'd1;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_ADD   = 2'd2;

  typedef struct packed {
    logic        done;
    logic [62:0] rem;
  } rem_res_t;

endpackage

/* design/sps_rem_unit.sv */
module sps_rem_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [63:0]         dividend,
  input  logic [62:0]         divisor,
  output sps_pkg::rem_res_t   res
);

  localparam int STEPS = 64;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      q_r;
  logic [63:0]      rem_r;
  logic [62:0]      div_r;
  logic [63:0]      rs;
  logic [64:0]      diff;

  // restoring remainder, one dividend bit per cycle
  assign rs   = {rem_r[62:0], q_r[63]};
  assign diff = {1'b0, rs} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= diff[64] ? rs : diff[63:0];
        q_r   <= {q_r[62:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r[62:0];

endmodule

/* design/sync_point_scheduler.sv */
// Channel  Ports                                              Handshake
// input    in_action, in_time_value, in_force_req              start & !busy
// result   out_next_sync_time, out_fired, out_table_full       out_valid, one cycle
// config   cfg_index, cfg_wdata                                cfg_we
//
// out_valid rises once an accepted item has passed its states. Start item: fire check,
// serial remainder unit, forming of the periodic point, scan of the extra point table.
// Firing query: a last-point check, then those states. A zero interval skips the
// remainder unit and point forming. Add item: scan only. Non-firing query: checks only.
// Reset is synchronous; the extra point table is not cleared, its count is.
// busy is high while an item is at work; results cannot be stalled.
module sync_point_scheduler #(
  parameter int MAX_EXTRA_POINTS = sps_pkg::MAX_EXTRA_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic signed [63:0]            in_time_value,
  input  logic                          in_force_req,
  output logic                          out_valid,
  output logic signed [63:0]            out_next_sync_time,
  output logic                          out_fired,
  output logic                          out_table_full,
  input  logic                          cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [62:0]                   cfg_wdata
);

  localparam int CW = $clog2(MAX_EXTRA_POINTS + 1);
  localparam int AW = (MAX_EXTRA_POINTS > 1) ? $clog2(MAX_EXTRA_POINTS) : 1;
  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE, S_QLAST, S_QNEXT, S_DIV, S_BASE, S_NT, S_SCAN
  } state_t;

  function automatic logic near(input logic signed [63:0] a,
                                input logic signed [63:0] b,
                                input logic [31:0]        tol);
    logic signed [64:0] d;
    logic signed [64:0] tw;
    d  = $signed({a[63], a}) - $signed({b[63], b});
    tw = $signed({33'b0, tol});
    return (d < tw) && (d > -tw);
  endfunction

  state_t             state_r;
  logic [1:0]         act_r;
  logic signed [63:0] t_r;
  logic               force_r;
  logic signed [63:0] last_r;
  logic               last_v_r;
  logic signed [63:0] next_r;
  logic [62:0]        iv_r;
  logic [31:0]        tol_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      idx_r;
  logic               cmp_v_r;
  logic               dup_r;
  logic signed [63:0] nt_r;
  logic signed [63:0] base_r;
  logic               rem_go_r;
  logic [63:0]        mag_r;
  logic               out_valid_r;
  logic signed [63:0] out_next_r;
  logic               out_fired_r;
  logic               out_full_r;

  logic signed [63:0] mem [MAX_EXTRA_POINTS];
  logic signed [63:0] mem_q_r;

  sps_pkg::rem_res_t  rem_res;
  logic               mem_re;
  logic               mem_we;
  logic               scan_end;
  logic               room;
  logic signed [64:0] nt_sum;
  logic               is_add;

  sps_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (rem_go_r),
    .dividend (mag_r),
    .divisor  (iv_r),
    .res      (rem_res)
  );

  assign is_add   = (act_r == sps_pkg::ACT_ADD);
  assign scan_end = (state_r == S_SCAN) && (idx_r == cnt_r) && !cmp_v_r;
  assign room     = (cnt_r < CW'(MAX_EXTRA_POINTS));
  assign mem_re   = (state_r == S_SCAN) && (idx_r < cnt_r);
  assign mem_we   = scan_end && is_add && !dup_r && room;
  assign nt_sum   = $signed({base_r[63], base_r}) + $signed({2'b00, iv_r});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= t_r;
    end
    if (mem_re) begin
      mem_q_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      last_v_r    <= 1'b0;
      next_r      <= '0;
      iv_r        <= '0;
      tol_r       <= 32'd1;
      cnt_r       <= '0;
      idx_r       <= '0;
      cmp_v_r     <= 1'b0;
      rem_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_fired_r <= 1'b0;
      out_full_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rem_go_r    <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == sps_pkg::CFG_SYNC_INTERVAL) begin
          iv_r <= cfg_wdata;
        end else if (cfg_index == sps_pkg::CFG_TIME_TOLERANCE) begin
          tol_r <= cfg_wdata[31:0];
        end
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r   <= in_action;
            t_r     <= in_time_value;
            force_r <= in_force_req;
            case (in_action)
              sps_pkg::ACT_START: begin
                last_r   <= in_time_value;
                last_v_r <= 1'b1;
                state_r  <= S_QNEXT;
              end
              sps_pkg::ACT_QUERY: state_r <= S_QLAST;
              sps_pkg::ACT_ADD: begin
                idx_r   <= '0;
                cmp_v_r <= 1'b0;
                dup_r   <= 1'b0;
                state_r <= S_SCAN;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_next_r  <= next_r;
                out_fired_r <= 1'b0;
                out_full_r  <= 1'b0;
              end
            endcase
          end
        end
        S_QLAST: begin
          if (last_v_r && near(t_r, last_r, tol_r)) begin
            out_valid_r <= 1'b1;
            out_next_r  <= next_r;
            out_fired_r <= 1'b0;
            out_full_r  <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_QNEXT;
          end
        end
        S_QNEXT: begin
          // start items pass through here with the fire decision forced
          if (act_r == sps_pkg::ACT_START || force_r || near(t_r, next_r, tol_r)) begin
            last_r   <= t_r;
            last_v_r <= 1'b1;
            idx_r    <= '0;
            cmp_v_r  <= 1'b0;
            dup_r    <= 1'b0;
            if (iv_r == '0) begin
              nt_r    <= t_r;
              state_r <= S_SCAN;
            end else begin
              mag_r    <= t_r[63] ? 64'(-t_r) : t_r;
              rem_go_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end else begin
            out_valid_r <= 1'b1;
            out_next_r  <= next_r;
            out_fired_r <= 1'b0;
            out_full_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (rem_res.done) begin
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          base_r  <= t_r[63] ? t_r + $signed({1'b0, rem_res.rem})
                             : t_r - $signed({1'b0, rem_res.rem});
          state_r <= S_NT;
        end
        S_NT: begin
          if (t_r[63] && rem_res.rem != '0) begin
            nt_r <= base_r;
          end else if (nt_sum[64:63] == 2'b01) begin
            nt_r <= INT64_MAX;
          end else begin
            nt_r <= nt_sum[63:0];
          end
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (cmp_v_r) begin
            if (is_add) begin
              if (mem_q_r == t_r) begin
                dup_r <= 1'b1;
              end
            end else if (mem_q_r > t_r && mem_q_r < nt_r) begin
              nt_r <= mem_q_r;
            end
          end
          if (mem_re) begin
            idx_r   <= idx_r + 1'b1;
            cmp_v_r <= 1'b1;
          end else begin
            cmp_v_r <= 1'b0;
          end
          if (scan_end) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (is_add) begin
              out_next_r  <= next_r;
              out_fired_r <= 1'b0;
              out_full_r  <= !dup_r && !room;
              if (mem_we) begin
                cnt_r <= cnt_r + 1'b1;
              end
            end else begin
              next_r      <= nt_r;
              out_next_r  <= nt_r;
              out_fired_r <= (act_r == sps_pkg::ACT_QUERY);
              out_full_r  <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_next_sync_time = out_next_r;
  assign out_fired          = out_fired_r;
  assign out_table_full     = out_full_r;

  a_out_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  a_accept_progress : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid) else $error("accepted item dropped");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_EXTRA_POINTS)) else $error("extra point count overflow");

  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fired && out_table_full)) else $error("fired and full together");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [sps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int N_EXTRA = sps_pkg::MAX_EXTRA_POINTS_DEF;
  localparam longint T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint T_MIN = 64'sh8000_0000_0000_0000;
  localparam longint ONE = 64'sh1_0000;
  localparam logic [62:0] IV_MAX = '1;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [63:0] next_time;
    logic               fired;
    logic               full;
  } sync_result_t;

  typedef struct {
    bit           is_cfg;
    logic [1:0]   act;
    longint       tval;
    logic         frc;
    bit           typed;
    sync_result_t res;
    logic [62:0]  ival;
    logic [62:0]  tword;
    bit           poke;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_action = sps_pkg::ACT_START;
  logic signed [63:0] in_time_value = '0;
  logic in_force_req = 1'b0;
  logic cfg_we = 1'b0;
  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index = sps_pkg::CFG_SYNC_INTERVAL;
  logic [62:0] cfg_wdata = '0;
  logic busy, out_valid, out_fired, out_table_full;
  logic signed [63:0] out_next_sync_time;

  sync_point_scheduler DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_time_value(in_time_value),
    .in_force_req(in_force_req),
    .out_valid(out_valid),
    .out_next_sync_time(out_next_sync_time),
    .out_fired(out_fired),
    .out_table_full(out_table_full),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // scheduler shadow state
  logic [62:0] sh_interval = '0;
  logic [31:0] sh_tol = 32'd1;
  longint last_pt = 0;
  bit last_ok = 1'b0;
  longint sched_pt = 0;
  longint extra_pts[N_EXTRA];
  int extra_n = 0;

  sync_result_t pending_results[$];
  stim_row_t dir_rows[$];
  sync_result_t got;
  int errors = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int drops_seen = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int unsigned cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic bit within_tol(input longint a, input longint b);
    logic [63:0] d;
    d = (a >= b) ? a - b : b - a;
    return d < {32'b0, sh_tol};
  endfunction

  function automatic longint next_point_after(input longint t);
    longint nt, iv, rc, base;
    nt = t;
    if (sh_interval != 0) begin
      iv = $signed({1'b0, sh_interval});
      rc = t % iv;
      base = t - rc;
      if (rc < 0) nt = base;
      else if (base > T_MAX - iv) nt = T_MAX;
      else nt = base + iv;
    end
    for (int i = 0; i < extra_n; i++)
      if (extra_pts[i] > t && extra_pts[i] < nt) nt = extra_pts[i];
    return nt;
  endfunction

  function automatic sync_result_t schedule_step(input logic [1:0] act, input longint t,
                                                 input logic frc);
    sync_result_t r;
    bit dup;
    r.fired = 1'b0;
    r.full = 1'b0;
    dup = 1'b0;
    case (act)
      sps_pkg::ACT_START: begin
        last_pt = t;
        last_ok = 1'b1;
        sched_pt = next_point_after(t);
      end
      sps_pkg::ACT_QUERY: begin
        if (!(last_ok && within_tol(t, last_pt)) && (frc || within_tol(t, sched_pt))) begin
          r.fired = 1'b1;
          last_pt = t;
          last_ok = 1'b1;
          sched_pt = next_point_after(t);
        end
      end
      sps_pkg::ACT_ADD: begin
        for (int i = 0; i < extra_n; i++)
          if (extra_pts[i] == t) dup = 1'b1;
        if (!dup) begin
          if (extra_n < N_EXTRA) begin
            extra_pts[extra_n] = t;
            extra_n++;
          end else begin
            r.full = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.next_time = sched_pt;
    return r;
  endfunction

  function automatic void item_row(input logic [1:0] act, input longint t, input logic frc,
                                   input bit typed, input longint nxt, input logic f,
                                   input logic u);
    stim_row_t row;
    row = '{default: 0};
    row.act = act;
    row.tval = t;
    row.frc = frc;
    row.typed = typed;
    row.res.next_time = nxt;
    row.res.fired = f;
    row.res.full = u;
    dir_rows.push_back(row);
  endfunction

  function automatic void cfg_row(input logic [62:0] iv, input logic [62:0] tw, input bit poke);
    stim_row_t row;
    row = '{default: 0};
    row.is_cfg = 1'b1;
    row.ival = iv;
    row.tword = tw;
    row.poke = poke;
    dir_rows.push_back(row);
  endfunction

  function automatic longint window_time();
    return longint'($urandom_range(160 * 65536)) - 80 * ONE;
  endfunction

  function automatic longint any_time();
    case ($urandom_range(9))
      0: return longint'({$urandom, $urandom});
      1: return T_MAX - longint'($urandom_range(3 * 65536));
      2: return T_MIN + longint'($urandom_range(3 * 65536));
      default: return window_time();
    endcase
  endfunction

  function automatic longint near_time(input longint base, input bit at_bound);
    longint off;
    if (at_bound) off = longint'(sh_tol);
    else off = (sh_tol == 0) ? 0 : longint'($urandom_range(sh_tol - 1));
    return $urandom_range(1) ? base + off : base - off;
  endfunction

  // wait until the block is idle with nothing outstanding
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
  endtask

  task automatic program_regs(input logic [62:0] ival, input logic [62:0] tword,
                              input bit poke);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= sps_pkg::CFG_SYNC_INTERVAL;
    cfg_wdata <= ival;
    @(posedge clk);
    cfg_index <= sps_pkg::CFG_TIME_TOLERANCE;
    cfg_wdata <= tword;
    @(posedge clk);
    if (poke) begin
      cfg_index <= CFG_IDX_SPARE;
      cfg_wdata <= 63'({$urandom, $urandom});
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sh_interval = ival;
    sh_tol = tword[31:0];
  endtask

  task automatic send_item(input logic [1:0] act, input longint t, input logic frc,
                           input bit typed, input sync_result_t typed_res);
    sync_result_t r;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_action <= act;
    in_time_value <= t;
    in_force_req <= frc;
    do @(posedge clk); while (busy);
    r = schedule_step(act, t, frc);
    pending_results.push_back(typed ? typed_res : r);
    if (act != ACT_NONE) items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_fired === 1'b1) fires_seen++;
      if (out_table_full === 1'b1) drops_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result next %h fired %b full %b", $time,
                 out_next_sync_time, out_fired, out_table_full);
      end else begin
        got = pending_results.pop_front();
        if (out_next_sync_time !== got.next_time) begin
          errors++;
          $display("%0t: next_sync_time expected %h got %h", $time, got.next_time,
                   out_next_sync_time);
        end
        if (out_fired !== got.fired) begin
          errors++;
          $display("%0t: fired expected %b got %b", $time, got.fired, out_fired);
        end
        if (out_table_full !== got.full) begin
          errors++;
          $display("%0t: table_full expected %b got %b", $time, got.full, out_table_full);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [1:0] act;
    longint t;
    logic frc;
    int roll;
    int rnd_items;
    logic [63:0] r64;
    logic [62:0] ival;
    logic [62:0] tword;
    bit poke;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: interval 0, tolerance 1
    item_row(sps_pkg::ACT_QUERY, 5, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_QUERY, 0, 1'b0, 1'b1, 0, 1'b1, 1'b0);
    item_row(sps_pkg::ACT_QUERY, 0, 1'b1, 1'b1, 0, 1'b0, 1'b0);
    cfg_row(63'(ONE), 63'd1, 1'b0);
    item_row(sps_pkg::ACT_START, T_MAX - 5, 1'b0, 1'b1, T_MAX, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_START, T_MIN, 1'b1, 1'b1, 64'sh8000_0000_0001_0000, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_START, -1, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_ADD, 64'sh8000, 1'b0, 1'b1, 0, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_START, 0, 1'b0, 1'b1, 64'sh8000, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_QUERY, 64'sh8000, 1'b0, 1'b1, 64'sh1_0000, 1'b1, 1'b0);
    item_row(sps_pkg::ACT_QUERY, 64'sh2_0000, 1'b1, 1'b1, 64'sh3_0000, 1'b1, 1'b0);
    item_row(ACT_NONE, -1, 1'b1, 1'b1, 64'sh3_0000, 1'b0, 1'b0);
    cfg_row(63'(ONE), 63'd0, 1'b0);
    item_row(sps_pkg::ACT_QUERY, 64'sh3_0000, 1'b0, 1'b1, 64'sh3_0000, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_QUERY, 64'sh3_0000, 1'b1, 1'b1, 64'sh4_0000, 1'b1, 1'b0);
    cfg_row(IV_MAX, 63'hFFFF_FFFF, 1'b1);
    item_row(sps_pkg::ACT_START, 0, 1'b0, 1'b1, 64'sh8000, 1'b0, 1'b0);
    for (int k = 1; k < N_EXTRA; k++)
      item_row(sps_pkg::ACT_ADD, 64'sh8000 + k * 64'sh4_8000, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    item_row(sps_pkg::ACT_ADD, T_MAX, 1'b0, 1'b1, 64'sh8000, 1'b0, 1'b1);
    item_row(sps_pkg::ACT_ADD, 64'sh8000, 1'b0, 1'b1, 64'sh8000, 1'b0, 1'b0);

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.is_cfg) program_regs(row.ival, row.tword, row.poke);
      else send_item(row.act, row.tval, row.frc, row.typed, row.res);
    end

    rnd_items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      r64 = {$urandom, $urandom};
      poke = 1'b0;
      case (ph)
        0: begin ival = 63'(ONE); tword = 63'h100; end
        1: begin
          ival = 63'($urandom_range(8 * 65536, 1));
          tword = 63'($urandom_range(16'hFFFF));
        end
        2: begin ival = '0; tword = 63'd1; end
        3: begin ival = IV_MAX; tword = 63'hFFFF_FFFF; end
        4: begin ival = r64[62:0]; tword = 63'({$urandom, $urandom}); end
        5: begin ival = 63'd1; tword = '0; end
        6: begin
          ival = 63'($urandom_range(4 * 65536, 1));
          tword = 63'($urandom_range(16'h4000, 16));
          poke = 1'b1;
        end
        default: begin ival = 63'(3 * ONE); tword = 63'h8000; end
      endcase
      program_regs(ival, tword, poke);
      for (int k = 0; k < 82; k++) begin
        idle_pct = (rnd_items < 220) ? 19 : (rnd_items < 440) ? 58 : 0;
        rnd_items++;
        if ($urandom_range(59) == 0) settle();
        roll = $urandom_range(99);
        frc = ($urandom_range(4) == 0);
        if (roll < 55) begin
          act = sps_pkg::ACT_QUERY;
          case ($urandom_range(9))
            0, 1, 2, 3, 4: t = near_time(sched_pt, 1'b0);
            5: t = near_time(sched_pt, 1'b1);
            6: t = near_time(last_pt, 1'b0);
            7: begin t = any_time(); frc = 1'b1; end
            default: t = any_time();
          endcase
        end else if (roll < 75) begin
          act = sps_pkg::ACT_START;
          t = any_time();
        end else if (roll < 95) begin
          act = sps_pkg::ACT_ADD;
          if (extra_n != 0 && $urandom_range(1)) t = extra_pts[$urandom_range(extra_n - 1)];
          else t = any_time();
        end else begin
          act = ACT_NONE;
          t = any_time();
        end
        send_item(act, t, frc, 1'b0, got);
      end
    end

    settle();
    repeat (100) @(posedge clk);
    $display("%0d items, %0d results: %0d fired, %0d dropped adds", items_sent,
             results_seen, fires_seen, drops_seen);
    $display("covered start/query/add/unused codes over 11 interval/tolerance settings");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sync_point_scheduler.f */
design/sps_pkg.sv
design/sps_rem_unit.sv
design/sync_point_scheduler.sv
tb/tb_top.sv
